### src/gcm_ghash_authenticator_macros.svh
// ---------------------------------------------------------------------------
// GHASH authenticator assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef GCM_GHASH_AUTHENTICATOR_MACROS_SVH
`define GCM_GHASH_AUTHENTICATOR_MACROS_SVH
`ifndef SYNTH
// Plain property, checked on every clock edge outside reset
`define GGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication
`define GGA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`else
`define GGA_ASSERT(lbl, prop, msg)
`define GGA_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

### src/ghash_pkg.sv
// ---------------------------------------------------------------------------
// GHASH package
// Widths, codes, shared types and the byte absorb helper of the authenticator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghash_pkg;

  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned MUL_STEPS   = 128;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [BLOCK_W-1:0] block_t;

  // Reflected GCM reduction polynomial, 0xE1 in the top byte
  localparam block_t REDUCE_POLY = {8'hE1, 120'd0};

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HI  = 2'd0,
    CFG_KEY_LO  = 2'd1,
    CFG_MASK_HI = 2'd2,
    CFG_MASK_LO = 2'd3
  } cfg_idx_e;

  // Status of the serial multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // XOR one byte into the block lane picked by the fill count, big-endian
  function automatic block_t absorb_byte(block_t acc, logic [FILL_W-1:0] fill,
                                         logic [BYTE_W-1:0] b);
    block_t r;
    r = acc;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      if (fill == FILL_W'(k)) begin
        r[(BLOCK_BYTES-1-k)*BYTE_W +: BYTE_W] = r[(BLOCK_BYTES-1-k)*BYTE_W +: BYTE_W] ^ b;
      end
    end
    return r;
  endfunction

endpackage

### src/ghash_gf_mul.sv
// ---------------------------------------------------------------------------
// GHASH bit-serial multiplier
// Multiplies a block by H in GF(2^128), one multiplicand bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcm_ghash_authenticator_macros.svh"

module ghash_gf_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ghash_pkg::block_t     x_i,
  input  ghash_pkg::block_t     h_i,
  output ghash_pkg::block_t     z_o,
  output ghash_pkg::mul_stat_t  stat_o
);
  import ghash_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MUL_STEPS - 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  block_t            x_q, v_q, z_q;
  block_t            z_d, v_d;

  // Add V when the current bit is set; halve V and reduce on carry out
  always_comb begin
    z_d = x_q[BLOCK_W-1] ? (z_q ^ v_q) : z_q;
    v_d = (v_q >> 1) ^ (v_q[0] ? REDUCE_POLY : '0);
  end

  // Step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the multiplicand out MSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      v_q <= h_i;
      z_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << 1;
      v_q <= v_d;
      z_q <= z_d;
    end
  end

  assign z_o         = z_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `GGA_ASSERT_IMP(a_no_restart, start_i, !busy_q, "multiplier started while busy")
  `GGA_ASSERT(a_done_pulse, done_q |=> !done_q, "done held for more than one cycle")
  `GGA_ASSERT(a_last_step, (busy_q && !start_i && cnt_q == LAST_STEP) |=> (done_q && !busy_q),
              "multiplier did not finish after the last step")

endmodule

### src/gcm_ghash_authenticator.sv
// ---------------------------------------------------------------------------
// GCM GHASH authenticator
// Takes start, header byte, text byte and finish items one at a time and
// returns one result per item: an accept/reject status and, on an accepted
// finish, the 128-bit tag GHASH(H, A, C) XOR E(K,Y0). Multiplications by H
// are triggered by a byte that completes a 16-byte block or the first text
// byte after a partial header block (one each) and by a finish (one or two).
// The bit-serial GF(2^128) multiplier consumes one accumulator bit per cycle.
// The user must write the hash key and tag mask through the configuration
// port while no item is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcm_ghash_authenticator_macros.svh"

module gcm_ghash_authenticator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [ghash_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ghash_pkg::HALF_W-1:0]       cfg_data_i,
  // Input items
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic [ghash_pkg::BYTE_W-1:0]       data_byte_i,
  // Result items
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               status_o,
  output logic                               tag_valid_o,
  output logic [ghash_pkg::HALF_W-1:0]       tag_high_o,
  output logic [ghash_pkg::HALF_W-1:0]       tag_low_o
);
  import ghash_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TEXT,
    PH_DONE
  } phase_e;

  // What follows a finished multiplication
  typedef enum logic [1:0] {
    AFT_EMIT,
    AFT_TEXT,
    AFT_LEN,
    AFT_TAG
  } after_e;

  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(BLOCK_BYTES - 1);

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  after_e               after_q, after_d;
  block_t               acc_q, acc_d;
  logic [COUNT_W-1:0]   hdr_cnt_q, hdr_cnt_d, txt_cnt_q, txt_cnt_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic                 res_status_q, res_status_d, res_tag_q, res_tag_d;
  block_t               key_q, mask_q;
  logic                 out_valid_q, status_q, tag_valid_q;
  block_t               tag_q;

  cmd_e                 cmd;
  block_t               len_block;
  logic                 mul_start;
  block_t               mul_z;
  mul_stat_t            mul_stat;
  logic                 emit_fire;

  assign cmd       = cmd_e'(command_i);
  assign len_block = {hdr_cnt_q, 3'b000, txt_cnt_q, 3'b000};
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  ghash_gf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (acc_d),
    .h_i     (key_q),
    .z_o     (mul_z),
    .stat_o  (mul_stat)
  );

  // Sequence one item: absorb, launch multiplications, then emit
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    after_d      = after_q;
    acc_d        = acc_q;
    hdr_cnt_d    = hdr_cnt_q;
    txt_cnt_d    = txt_cnt_q;
    fill_d       = fill_q;
    byte_d       = byte_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    mul_start    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = 1'b0;
          res_tag_d    = 1'b0;
          state_d      = ST_EMIT;
          case (cmd)
            CMD_START: begin
              acc_d     = '0;
              hdr_cnt_d = '0;
              txt_cnt_d = '0;
              fill_d    = '0;
              phase_d   = PH_HEADER;
            end
            CMD_HEADER: begin
              if (phase_q != PH_HEADER) begin
                res_status_d = 1'b1;
              end else begin
                acc_d     = absorb_byte(acc_q, fill_q, data_byte_i);
                hdr_cnt_d = hdr_cnt_q + COUNT_W'(1);
                fill_d    = fill_q + FILL_W'(1);
                if (fill_q == LAST_FILL) begin
                  mul_start = 1'b1;
                  after_d   = AFT_EMIT;
                  state_d   = ST_MUL;
                end
              end
            end
            CMD_TEXT: begin
              if (phase_q == PH_DONE) begin
                res_status_d = 1'b1;
              end else if (phase_q == PH_HEADER && fill_q != '0) begin
                // Close the partial header block first, hold the byte
                mul_start = 1'b1;
                after_d   = AFT_TEXT;
                byte_d    = data_byte_i;
                phase_d   = PH_TEXT;
                fill_d    = '0;
                state_d   = ST_MUL;
              end else begin
                phase_d   = PH_TEXT;
                acc_d     = absorb_byte(acc_q, fill_q, data_byte_i);
                txt_cnt_d = txt_cnt_q + COUNT_W'(1);
                fill_d    = fill_q + FILL_W'(1);
                if (fill_q == LAST_FILL) begin
                  mul_start = 1'b1;
                  after_d   = AFT_EMIT;
                  state_d   = ST_MUL;
                end
              end
            end
            CMD_FINISH: begin
              if (phase_q == PH_DONE) begin
                res_status_d = 1'b1;
              end else begin
                phase_d   = PH_DONE;
                mul_start = 1'b1;
                state_d   = ST_MUL;
                if (fill_q != '0) begin
                  after_d = AFT_LEN;
                  fill_d  = '0;
                end else begin
                  acc_d   = acc_q ^ len_block;
                  after_d = AFT_TAG;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          acc_d = mul_z;
          case (after_q)
            AFT_EMIT: state_d = ST_EMIT;
            AFT_TEXT: begin
              acc_d     = absorb_byte(mul_z, '0, byte_q);
              txt_cnt_d = txt_cnt_q + COUNT_W'(1);
              fill_d    = FILL_W'(1);
              state_d   = ST_EMIT;
            end
            AFT_LEN: begin
              // Fold in the length block and multiply once more
              acc_d     = mul_z ^ len_block;
              mul_start = 1'b1;
              after_d   = AFT_TAG;
            end
            AFT_TAG: begin
              acc_d     = '0;
              res_tag_d = 1'b1;
              state_d   = ST_EMIT;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, message state, configuration and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HEADER;
      after_q      <= AFT_EMIT;
      acc_q        <= '0;
      hdr_cnt_q    <= '0;
      txt_cnt_q    <= '0;
      fill_q       <= '0;
      res_status_q <= 1'b0;
      res_tag_q    <= 1'b0;
      key_q        <= '0;
      mask_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      after_q      <= after_d;
      acc_q        <= acc_d;
      hdr_cnt_q    <= hdr_cnt_d;
      txt_cnt_q    <= txt_cnt_d;
      fill_q       <= fill_d;
      res_status_q <= res_status_d;
      res_tag_q    <= res_tag_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_KEY_HI:  key_q[BLOCK_W-1:HALF_W]  <= cfg_data_i;
          CFG_KEY_LO:  key_q[HALF_W-1:0]        <= cfg_data_i;
          CFG_MASK_HI: mask_q[BLOCK_W-1:HALF_W] <= cfg_data_i;
          CFG_MASK_LO: mask_q[HALF_W-1:0]       <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and held text byte
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (emit_fire) begin
      status_q    <= res_status_q;
      tag_valid_q <= res_tag_q;
      tag_q       <= res_tag_q ? (mul_z ^ mask_q) : '0;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign tag_valid_o = tag_valid_q;
  assign tag_high_o  = tag_q[BLOCK_W-1:HALF_W];
  assign tag_low_o   = tag_q[HALF_W-1:0];

  `GGA_ASSERT_IMP(a_idle_mul_quiet, state_q == ST_IDLE, !mul_stat.busy,
                  "multiplier running while no item is in flight")
  `GGA_ASSERT_IMP(a_done_only_in_mul, mul_stat.done, state_q == ST_MUL,
                  "multiplier finished outside the multiply state")
  `GGA_ASSERT_IMP(a_finished_clean, (state_q == ST_IDLE) && (phase_q == PH_DONE),
                  (fill_q == '0) && (acc_q == '0),
                  "accumulator not cleared after a finished message")
  `GGA_ASSERT_IMP(a_reject_no_tag, out_valid_o && status_o,
                  !tag_valid_o && (tag_high_o == '0) && (tag_low_o == '0),
                  "rejected item carries a tag")

endmodule
